@@ src/eq3_pkg.sv @@
// shared types, constants and microcode program for the three band equalizer
package eq3_pkg;

  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 18;
  localparam int COEFF_W  = 18;
  localparam int GAIN_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int POLE_W   = 32;
  localparam int MUL_A_W  = 34;
  localparam int MUL_B_W  = 19;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int COEFF_FRAC = 17;
  localparam int OUT_FRAC   = 28;
  localparam int STEP_W   = PROD_W - COEFF_FRAC;
  localparam int QUOT_W   = PROD_W - OUT_FRAC;
  localparam int PC_W     = 5;
  localparam int SEL_W    = 3;

  localparam logic [CFG_AW-1:0] REG_LOW_COEFF  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_HIGH_COEFF = 3'd1;
  localparam logic [CFG_AW-1:0] REG_LOW_GAIN   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MID_GAIN   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_HIGH_GAIN  = 3'd4;

  localparam logic [COEFF_W-1:0] LOW_COEFF_RST  = 18'd15090;
  localparam logic [COEFF_W-1:0] HIGH_COEFF_RST = 18'd84264;
  localparam logic [GAIN_W-1:0]  GAIN_RST       = 16'd4096;

  typedef enum logic [1:0] {
    J_NEXT = 2'd0,
    J_IN   = 2'd1,
    J_OUT  = 2'd2,
    J_GO   = 2'd3
  } jmp_t;

  typedef enum logic [2:0] {
    M_NONE = 3'd0,
    M_POLE = 3'd1,
    M_LOW  = 3'd2,
    M_MID  = 3'd3,
    M_HIGH = 3'd4
  } mul_t;

  typedef enum logic [1:0] {
    A_NONE = 2'd0,
    A_CLR  = 2'd1,
    A_ADD  = 2'd2
  } acc_t;

  typedef struct packed {
    jmp_t             jmp;
    logic [PC_W-1:0]  target;
    logic             rd_en;
    logic [SEL_W-1:0] rd_sel;
    logic             wr_en;
    logic [SEL_W-1:0] wr_sel;
    mul_t             mul;
    logic             coeff_hi;
    logic             load_x;
    logic             save_low;
    logic             save_high;
    acc_t             acc;
    logic             quot;
    logic             fin;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '0;
    case (pc)
      5'd0: begin
        c.jmp = J_IN;
      end
      5'd1: begin
        c.rd_en = 1'b1; c.rd_sel = 3'd0; c.load_x = 1'b1;
      end
      5'd2: begin
        c.mul = M_POLE; c.rd_en = 1'b1; c.rd_sel = 3'd1;
      end
      5'd3: begin
        c.wr_en = 1'b1; c.wr_sel = 3'd0;
      end
      5'd4: begin
        c.mul = M_POLE; c.rd_en = 1'b1; c.rd_sel = 3'd2;
      end
      5'd5: begin
        c.wr_en = 1'b1; c.wr_sel = 3'd1;
      end
      5'd6: begin
        c.mul = M_POLE; c.rd_en = 1'b1; c.rd_sel = 3'd3;
      end
      5'd7: begin
        c.wr_en = 1'b1; c.wr_sel = 3'd2;
      end
      5'd8: begin
        c.mul = M_POLE; c.rd_en = 1'b1; c.rd_sel = 3'd4;
      end
      5'd9: begin
        c.wr_en = 1'b1; c.wr_sel = 3'd3; c.save_low = 1'b1; c.load_x = 1'b1;
      end
      5'd10: begin
        c.mul = M_POLE; c.coeff_hi = 1'b1; c.rd_en = 1'b1; c.rd_sel = 3'd5;
      end
      5'd11: begin
        c.wr_en = 1'b1; c.wr_sel = 3'd4;
      end
      5'd12: begin
        c.mul = M_POLE; c.coeff_hi = 1'b1; c.rd_en = 1'b1; c.rd_sel = 3'd6;
      end
      5'd13: begin
        c.wr_en = 1'b1; c.wr_sel = 3'd5;
      end
      5'd14: begin
        c.mul = M_POLE; c.coeff_hi = 1'b1; c.rd_en = 1'b1; c.rd_sel = 3'd7;
      end
      5'd15: begin
        c.wr_en = 1'b1; c.wr_sel = 3'd6;
      end
      5'd16: begin
        c.mul = M_POLE; c.coeff_hi = 1'b1;
      end
      5'd17: begin
        c.wr_en = 1'b1; c.wr_sel = 3'd7; c.save_high = 1'b1;
      end
      5'd18: begin
        c.mul = M_LOW; c.acc = A_CLR;
      end
      5'd19: begin
        c.mul = M_MID; c.acc = A_ADD;
      end
      5'd20: begin
        c.mul = M_HIGH; c.acc = A_ADD;
      end
      5'd21: begin
        c.acc = A_ADD;
      end
      5'd22: begin
        c.quot = 1'b1;
      end
      5'd23: begin
        c.fin = 1'b1; c.jmp = J_OUT; c.target = 5'd0;
      end
      default: begin
        c.jmp = J_GO; c.target = 5'd0;
      end
    endcase
    return c;
  endfunction

endpackage

@@ src/eq3_sequencer.sv @@
// microcode step counter with conditional jumps
module eq3_sequencer
  import eq3_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  out_valid,
  input  logic  out_ready,
  output ctrl_t ctl
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            out_stall;

  assign ctl       = ucode(pc_r);
  assign out_stall = out_valid && !out_ready;

  always_comb begin
    pc_nxt = pc_r;
    case (ctl.jmp)
      J_NEXT: pc_nxt = pc_r + PC_W'(1);
      J_IN:   pc_nxt = in_valid ? pc_r + PC_W'(1) : pc_r;
      J_OUT:  pc_nxt = out_stall ? pc_r : ctl.target;
      J_GO:   pc_nxt = ctl.target;
      default: pc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ src/eq3_datapath.sv @@
// pole memory, history, shared multiplier, accumulator and output register
module eq3_datapath
  import eq3_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctrl_t                      ctl,
  input  logic                       in_valid,
  input  logic                       in_channel,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic [COEFF_W-1:0]         low_coeff,
  input  logic [COEFF_W-1:0]         high_coeff,
  input  logic [GAIN_W-1:0]          low_gain,
  input  logic [GAIN_W-1:0]          mid_gain,
  input  logic [GAIN_W-1:0]          high_gain,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_clipped
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH  = 8 * CHANNELS;
  localparam int AW     = $clog2(DEPTH);

  logic [POLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [POLE_W-1:0] rd_data_r;
  logic              rd_vld_r;
  logic [AW-1:0]     rd_addr, wr_addr;

  logic signed [SAMPLE_W-1:0] hist_r [CHANNELS][3];
  logic [CH_W-1:0]            ch_r, ch_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, delayed_r;

  logic signed [POLE_W-1:0]  in_r, in_nxt, p_hold_r, low_r, high_r, pole_rd, x_val;
  logic signed [POLE_W-1:0]  new_pole;
  logic signed [MUL_A_W-1:0] mul_a, delayed_x;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r, acc_r, biased;
  logic signed [STEP_W-1:0]  step;
  logic signed [STEP_W:0]    psum;
  logic signed [QUOT_W-1:0]  q_r;
  logic [COEFF_W-1:0]        coeff;
  logic                      in_fire, fin_go, out_valid_r;

  assign in_fire   = in_valid && (ctl.jmp == J_IN);
  assign fin_go    = ctl.fin && !(out_valid_r && !out_ready);
  assign out_valid = out_valid_r;
  assign ch_nxt    = (CHANNELS == 1) ? '0 : CH_W'(in_channel);

  assign rd_addr = AW'({ch_r, ctl.rd_sel});
  assign wr_addr = AW'({ch_r, ctl.wr_sel});
  assign pole_rd = rd_vld_r ? $signed(rd_data_r) : '0;
  assign x_val   = {sample_r, 16'b0};
  assign delayed_x = MUL_A_W'($signed({delayed_r, 16'b0}));
  assign coeff   = ctl.coeff_hi ? high_coeff : low_coeff;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.mul)
      M_POLE: begin
        mul_a = MUL_A_W'(in_r) - MUL_A_W'(pole_rd);
        mul_b = $signed({1'b0, coeff});
      end
      M_LOW: begin
        mul_a = MUL_A_W'(low_r);
        mul_b = $signed({3'b0, low_gain});
      end
      M_MID: begin
        mul_a = MUL_A_W'(high_r) - MUL_A_W'(low_r);
        mul_b = $signed({3'b0, mid_gain});
      end
      M_HIGH: begin
        mul_a = delayed_x - MUL_A_W'(high_r);
        mul_b = $signed({3'b0, high_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // pole update with floor shift and 32-bit saturation
  always_comb begin
    step = STEP_W'(prod_r >>> COEFF_FRAC);
    psum = (STEP_W+1)'(p_hold_r) + (STEP_W+1)'(step);
    if (psum[STEP_W:POLE_W-1] == '0 || psum[STEP_W:POLE_W-1] == '1) begin
      new_pole = psum[POLE_W-1:0];
    end else if (psum[STEP_W]) begin
      new_pole = {1'b1, {(POLE_W-1){1'b0}}};
    end else begin
      new_pole = {1'b0, {(POLE_W-1){1'b1}}};
    end
    in_nxt = ctl.load_x ? x_val : new_pole;
  end

  assign biased = acc_r + (acc_r[PROD_W-1] ? PROD_W'((64'd1 << OUT_FRAC) - 64'd1) : '0);

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
    if (ctl.wr_en) begin
      mem[wr_addr] <= new_pole;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < 3; k++) begin
          hist_r[c][k] <= '0;
        end
      end
    end else if (in_fire) begin
      hist_r[ch_nxt][2] <= hist_r[ch_nxt][1];
      hist_r[ch_nxt][1] <= hist_r[ch_nxt][0];
      hist_r[ch_nxt][0] <= in_sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch_r      <= ch_nxt;
      sample_r  <= in_sample_in;
      delayed_r <= hist_r[ch_nxt][2];
    end
    if (ctl.mul != M_NONE) begin
      prod_r <= mul_a * mul_b;
    end
    if (ctl.mul == M_POLE) begin
      p_hold_r <= pole_rd;
    end
    if (ctl.load_x || ctl.wr_en) begin
      in_r <= in_nxt;
    end
    if (ctl.save_low) begin
      low_r <= new_pole;
    end
    if (ctl.save_high) begin
      high_r <= new_pole;
    end
    case (ctl.acc)
      A_CLR:   acc_r <= '0;
      A_ADD:   acc_r <= acc_r + prod_r;
      default: acc_r <= acc_r;
    endcase
    if (ctl.quot) begin
      q_r <= QUOT_W'(biased >>> OUT_FRAC);
    end
    if (fin_go) begin
      if (q_r > QUOT_W'(32767)) begin
        out_sample_out <= 16'sh7fff;
        out_clipped    <= 1'b1;
      end else if (q_r < -QUOT_W'(32768)) begin
        out_sample_out <= 16'sh8000;
        out_clipped    <= 1'b1;
      end else begin
        out_sample_out <= q_r[SAMPLE_W-1:0];
        out_clipped    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

@@ src/three_band_audio_equalizer.sv @@
// three band equalizer top level with configuration registers
//
// input channel: in_valid/in_ready carry one transaction of a channel number
// and a signed 16-bit sample. output channel: out_valid/out_ready carry the
// equalized sample and a clip flag, one result per input transaction.
// configuration: cfg_wr_en writes cfg_wr_data to the register at cfg_addr
// (0 low coeff, 1 high coeff, 2 low gain, 3 mid gain, 4 high gain); other
// indexes are ignored. write only while no transaction is in flight.
// a microcode program of 24 steps runs each sample: eight dependent pole
// updates of two steps each on one shared multiplier, three gain products,
// then rounding. a sample is taken only at the first step, once the result
// of the previous one is registered. the next sample is accepted while a
// result still waits; if the receiver stalls, the program holds at its last
// step until the output register is free.
// reset clears the program counter, output valid, all pole and history
// state and loads the default coefficients and unity gains.
module three_band_audio_equalizer
  import eq3_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_channel,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_clipped,
  input  logic                       cfg_wr_en,
  input  logic [CFG_AW-1:0]          cfg_addr,
  input  logic [CFG_DW-1:0]          cfg_wr_data
);

  ctrl_t              ctl;
  logic [COEFF_W-1:0] low_coeff_r, high_coeff_r;
  logic [GAIN_W-1:0]  low_gain_r, mid_gain_r, high_gain_r;

  assign in_ready = (ctl.jmp == J_IN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_coeff_r  <= LOW_COEFF_RST;
      high_coeff_r <= HIGH_COEFF_RST;
      low_gain_r   <= GAIN_RST;
      mid_gain_r   <= GAIN_RST;
      high_gain_r  <= GAIN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_LOW_COEFF:  low_coeff_r  <= cfg_wr_data;
        REG_HIGH_COEFF: high_coeff_r <= cfg_wr_data;
        REG_LOW_GAIN:   low_gain_r   <= cfg_wr_data[GAIN_W-1:0];
        REG_MID_GAIN:   mid_gain_r   <= cfg_wr_data[GAIN_W-1:0];
        REG_HIGH_GAIN:  high_gain_r  <= cfg_wr_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  eq3_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  eq3_datapath #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .in_valid       (in_valid),
    .in_channel     (in_channel),
    .in_sample_in   (in_sample_in),
    .low_coeff      (low_coeff_r),
    .high_coeff     (high_coeff_r),
    .low_gain       (low_gain_r),
    .mid_gain       (mid_gain_r),
    .high_gain      (high_gain_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped)
  );

endmodule

@@ src/eq3_checker.sv @@
// port-level assertions for the equalizer, bound to the top level
module eq3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_sample_out,
  input logic        out_clipped
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out) && $stable(out_clipped))
    else $error("output transaction changed while stalled");

  a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> (out_sample_out == 16'h7fff || out_sample_out == 16'h8000))
    else $error("clipped result not at a bound");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction");

endmodule

bind three_band_audio_equalizer eq3_checker u_chk (.*);
